// File: hw/rtl/miu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miu_pkg
// Shared opcodes, constants and types of the integer execute unit.
// ----------------------------------------------------------------------------
package miu_pkg;

    localparam int unsigned RegCount = 32;
    localparam int unsigned RegAddrW = 5;
    localparam int unsigned WordW    = 32;

    localparam logic [31:0] MASK_LOW24  = 32'h00ffffff;
    localparam logic [31:0] MASK_HIGH24 = 32'hffffff00;
    localparam logic [31:0] MASK_ALIGN  = 32'hfffffffc;
    localparam logic [31:0] MASK_WORD   = 32'hffffffff;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,  OP_ADDU = 5'd1,  OP_ADDI = 5'd2,  OP_ADDIU = 5'd3,
        OP_SUB   = 5'd4,  OP_SUBU = 5'd5,  OP_MULT = 5'd6,  OP_MULTU = 5'd7,
        OP_DIV   = 5'd8,  OP_DIVU = 5'd9,  OP_LB   = 5'd10, OP_LBU   = 5'd11,
        OP_LH    = 5'd12, OP_LHU  = 5'd13, OP_LW   = 5'd14, OP_LWL   = 5'd15,
        OP_LWR   = 5'd16, OP_SB   = 5'd17, OP_SH   = 5'd18, OP_SW    = 5'd19,
        OP_SWL   = 5'd20, OP_SWR  = 5'd21
    } opcode_t;

    typedef struct packed {
        logic        start;
        logic        is_signed;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } md_rsp_t;

endpackage

// File: hw/rtl/miu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miu_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module miu_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr_a,
    input  logic [$clog2(Depth)-1:0] raddr_b,
    output logic [Width-1:0]         rdata_a,
    output logic [Width-1:0]         rdata_b
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// File: hw/rtl/miu_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miu_muldiv
// Multiply by 16x32 partial products, low half then high half, plus a sign step,
// and a radix-2 restoring divide, with R3000 divide-by-zero results.
// ----------------------------------------------------------------------------
module miu_muldiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  miu_pkg::md_req_t  req,
    output miu_pkg::md_rsp_t  rsp
);
    import miu_pkg::*;

    logic        busy_reg, busy_next;
    logic        div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] ma_reg, ma_next;      // multiplicand / dividend shift
    logic [31:0] mb_reg, mb_next;      // multiplier / divisor magnitude
    logic [63:0] acc_reg, acc_next;
    logic [32:0] rem_reg, rem_next;
    logic        negq_reg, negq_next, negr_reg, negr_next;
    logic        sgn_reg, sgn_next;
    logic        zero_reg, zero_next;
    logic [31:0] a0_reg, a0_next;
    logic        done_reg, done_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;

    logic [31:0] abs_a, abs_b;
    logic [47:0] pp;
    logic [32:0] trial;
    logic [63:0] prod_s;

    always_comb begin
        abs_a = (req.is_signed && req.a[31]) ? (32'd0 - req.a) : req.a;
        abs_b = (req.is_signed && req.b[31]) ? (32'd0 - req.b) : req.b;
        pp    = {32'd0, cnt_reg[0] ? ma_reg[31:16] : ma_reg[15:0]} * {16'd0, mb_reg};
        trial = {rem_reg[31:0], ma_reg[31]} - {1'b0, mb_reg};
        prod_s = negq_reg ? (64'd0 - acc_reg) : acc_reg;

        busy_next = busy_reg; div_next = div_reg; cnt_next = cnt_reg;
        ma_next = ma_reg; mb_next = mb_reg; acc_next = acc_reg; rem_next = rem_reg;
        negq_next = negq_reg; negr_next = negr_reg; sgn_next = sgn_reg;
        zero_next = zero_reg; a0_next = a0_reg;
        done_next = 1'b0; hi_next = hi_reg; lo_next = lo_reg;

        if (!busy_reg && req.start) begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = '0;
            ma_next   = abs_a;
            mb_next   = abs_b;
            acc_next  = '0;
            rem_next  = '0;
            negq_next = req.is_signed && (req.a[31] ^ req.b[31]);
            negr_next = req.is_signed && req.a[31];
            sgn_next  = req.is_signed;
            zero_next = (req.b == 32'd0);
            a0_next   = req.a;
        end else if (busy_reg && !div_reg) begin
            if (cnt_reg[1]) begin
                // apply the product sign in a step of its own
                busy_next = 1'b0;
                done_next = 1'b1;
                {hi_next, lo_next} = prod_s;
            end else begin
                if (cnt_reg[0]) begin
                    acc_next = acc_reg + {pp, 16'd0};
                end else begin
                    acc_next = acc_reg + {16'd0, pp};
                end
                cnt_next = cnt_reg + 6'd1;
            end
        end else if (busy_reg) begin
            // shift one dividend bit into the partial remainder
            if (!trial[32]) begin
                rem_next = {1'b0, trial[31:0]};
            end else begin
                rem_next = {rem_reg[31:0], ma_reg[31]};
            end
            ma_next  = {ma_reg[30:0], !trial[32]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg) begin
                    hi_next = a0_reg;
                    lo_next = (sgn_reg && a0_reg[31]) ? 32'd1 : MASK_WORD;
                end else begin
                    lo_next = negq_reg ? (32'd0 - ma_next) : ma_next;
                    hi_next = negr_reg ? (32'd0 - rem_next[31:0]) : rem_next[31:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        div_reg <= div_next; cnt_reg <= cnt_next; ma_reg <= ma_next; mb_reg <= mb_next;
        acc_reg <= acc_next; rem_reg <= rem_next; negq_reg <= negq_next;
        negr_reg <= negr_next; sgn_reg <= sgn_next; zero_reg <= zero_next;
        a0_reg <= a0_next; hi_reg <= hi_next; lo_reg <= lo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.hi   = hi_reg;
    assign rsp.lo   = lo_reg;
endmodule

// File: hw/rtl/mips_integer_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_integer_execute_unit
// Executes one decoded integer instruction against the register file.
// ----------------------------------------------------------------------------
// ALU, load and store items go through register file read, execute with write
// back, then the output register; multiply and divide also wait for the shared
// multiply/divide unit. One item at a time: no new item is taken until the last
// result is loaded into the output register, which holds while its earlier
// result is not yet taken. Reset clears the register file by a sweep, one entry
// per cycle, during which no item is accepted; HI and LO reset to zero at once.
module mips_integer_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_opcode,
    input  logic [4:0]  s_dest_index,
    input  logic [4:0]  s_source_index,
    input  logic [4:0]  s_target_index,
    input  logic signed [15:0] s_immediate,
    input  logic [31:0] s_access_address,
    input  logic [31:0] s_memory_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_store_valid,
    output logic [31:0] m_store_address,
    output logic [31:0] m_store_word,
    output logic        m_register_written,
    output logic [31:0] m_written_value,
    output logic        m_overflow
);
    import miu_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_EXEC  = 6'b001000,
        ST_MD    = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [RegAddrW:0] clr_reg, clr_next;

    logic [4:0]  op_reg, rd_reg, rs_reg, rt_reg;
    logic [15:0] imm_reg;
    logic [31:0] addr_reg, mem_reg;
    logic [31:0] hi_reg, lo_reg;

    logic        we;
    logic [4:0]  waddr;
    logic [31:0] wdata, ra, rb;

    md_req_t req;
    md_rsp_t rsp;

    logic        ov_valid_reg;
    logic        o_sv_reg, o_rw_reg, o_ov_reg;
    logic [31:0] o_sa_reg, o_sw_reg, o_wv_reg;

    miu_ram #(.Width(WordW), .Depth(RegCount)) u_regs (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(rs_reg), .raddr_b(rt_reg), .rdata_a(ra), .rdata_b(rb)
    );

    miu_muldiv u_md (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    // execute datapath
    logic [31:0] a, b, imm, value;
    logic [4:0]  shift, hshift, dst;
    logic        st_valid, wr, ovf;
    logic [31:0] st_word;
    logic        is_md;

    always_comb begin
        a = (rs_reg == 5'd0) ? 32'd0 : ra;
        b = (rt_reg == 5'd0) ? 32'd0 : rb;
        imm = {{16{imm_reg[15]}}, imm_reg};
        shift  = {addr_reg[1:0], 3'b000};
        hshift = {addr_reg[1], 4'b0000};
        st_valid = 1'b0; wr = 1'b0; ovf = 1'b0;
        st_word = '0; value = '0; dst = '0; is_md = 1'b0;
        case (op_reg)
            OP_ADD, OP_ADDU: begin
                value = a + b; dst = rd_reg; wr = 1'b1;
                ovf = (op_reg == OP_ADD) && ((a[31] ^ value[31]) & (b[31] ^ value[31]));
            end
            OP_ADDI, OP_ADDIU: begin
                value = a + imm; dst = rt_reg; wr = 1'b1;
                ovf = (op_reg == OP_ADDI) && ((a[31] ^ value[31]) & (imm[31] ^ value[31]));
            end
            OP_SUB, OP_SUBU: begin
                value = a - b; dst = rd_reg; wr = 1'b1;
                ovf = (op_reg == OP_SUB) && ((a[31] ^ b[31]) & (a[31] ^ value[31]));
            end
            OP_MULT, OP_MULTU, OP_DIV, OP_DIVU: is_md = 1'b1;
            OP_LB:  begin value = {{24{mem_reg[shift+7]}}, 8'(mem_reg >> shift)};
                    dst = rt_reg; wr = 1'b1; end
            OP_LBU: begin value = {24'd0, 8'(mem_reg >> shift)}; dst = rt_reg; wr = 1'b1; end
            OP_LH:  begin value = {{16{mem_reg[hshift+15]}}, 16'(mem_reg >> hshift)};
                    dst = rt_reg; wr = 1'b1; end
            OP_LHU: begin value = {16'd0, 16'(mem_reg >> hshift)}; dst = rt_reg; wr = 1'b1; end
            OP_LW:  begin value = mem_reg; dst = rt_reg; wr = 1'b1; end
            OP_LWL: begin
                value = (b & (MASK_LOW24 >> shift)) | (mem_reg << (5'd24 - shift));
                dst = rt_reg; wr = 1'b1;
            end
            OP_LWR: begin
                value = (b & (MASK_HIGH24 << (5'd24 - shift))) | (mem_reg >> shift);
                dst = rt_reg; wr = 1'b1;
            end
            OP_SB: begin
                st_word = (mem_reg & ~(32'h000000ff << shift)) | ({24'd0, b[7:0]} << shift);
                st_valid = 1'b1;
            end
            OP_SH: begin
                st_word = (mem_reg & ~(32'h0000ffff << hshift)) | ({16'd0, b[15:0]} << hshift);
                st_valid = 1'b1;
            end
            OP_SW: begin st_word = b; st_valid = 1'b1; end
            OP_SWL: begin
                st_word = (b >> (5'd24 - shift)) | (mem_reg & (MASK_HIGH24 << shift));
                st_valid = 1'b1;
            end
            OP_SWR: begin
                st_word = (b << shift) | (mem_reg & (MASK_LOW24 >> (5'd24 - shift)));
                st_valid = 1'b1;
            end
            default: ;
        endcase
        if (ovf || dst == 5'd0) wr = 1'b0;
        if (!wr) value = '0;
    end

    assign req.start     = (state_reg == ST_EXEC) && is_md;
    assign req.is_signed = (op_reg == OP_MULT) || (op_reg == OP_DIV);
    assign req.is_div    = (op_reg == OP_DIV) || (op_reg == OP_DIVU);
    assign req.a         = a;
    assign req.b         = b;

    always_comb begin
        we = 1'b0; waddr = dst; wdata = value;
        if (state_reg == ST_CLEAR) begin
            we = 1'b1; waddr = clr_reg[RegAddrW-1:0]; wdata = '0;
        end else if (state_reg == ST_EXEC) begin
            we = wr;
        end
    end

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (RegAddrW+1)'(RegCount - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:  if (s_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  state_next = is_md ? ST_MD : ST_OUT;
            ST_MD:    if (rsp.done) state_next = ST_OUT;
            ST_OUT:   if (!ov_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            ov_valid_reg <= 1'b0;
            hi_reg       <= '0;
            lo_reg       <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (rsp.done) begin
                hi_reg <= rsp.hi;
                lo_reg <= rsp.lo;
            end
            // hold the result until its transfer; next item result follows
            if (state_reg == ST_OUT && (!ov_valid_reg || m_ready)) begin
                ov_valid_reg <= 1'b1;
            end else if (m_ready) begin
                ov_valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            op_reg <= s_opcode; rd_reg <= s_dest_index; rs_reg <= s_source_index;
            rt_reg <= s_target_index; imm_reg <= s_immediate;
            addr_reg <= s_access_address; mem_reg <= s_memory_word;
        end
        if (state_reg == ST_EXEC) begin
            o_sv_reg <= st_valid;
            o_sa_reg <= st_valid ? (addr_reg & MASK_ALIGN) : 32'd0;
            o_sw_reg <= st_word;
            o_rw_reg <= wr;
            o_wv_reg <= value;
            o_ov_reg <= ovf;
        end
    end

    // output register: loaded from the execute results on the way out
    logic        r_sv_reg, r_rw_reg, r_ov_reg;
    logic [31:0] r_sa_reg, r_sw_reg, r_wv_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!ov_valid_reg || m_ready)) begin
            r_sv_reg <= o_sv_reg; r_sa_reg <= o_sa_reg; r_sw_reg <= o_sw_reg;
            r_rw_reg <= o_rw_reg; r_wv_reg <= o_wv_reg; r_ov_reg <= o_ov_reg;
        end
    end

    assign m_valid            = ov_valid_reg;
    assign m_store_valid      = r_sv_reg;
    assign m_store_address    = r_sa_reg;
    assign m_store_word       = r_sw_reg;
    assign m_register_written = r_rw_reg;
    assign m_written_value    = r_wv_reg;
    assign m_overflow         = r_ov_reg;

    logic unused_hilo;
    assign unused_hilo = ^{hi_reg, lo_reg};
endmodule

// File: bench/mips_integer_execute_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_checker
// Watches both channels of the execute unit, keeps its own register file and
// HI/LO, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [4:0]  s_opcode,
    input  logic [4:0]  s_dest_index,
    input  logic [4:0]  s_source_index,
    input  logic [4:0]  s_target_index,
    input  logic [15:0] s_immediate,
    input  logic [31:0] s_access_address,
    input  logic [31:0] s_memory_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_store_valid,
    input  logic [31:0] m_store_address,
    input  logic [31:0] m_store_word,
    input  logic        m_register_written,
    input  logic [31:0] m_written_value,
    input  logic        m_overflow,
    output int          error_count,
    output int          pending_count,
    output int          result_count
);
    import miu_pkg::*;

    typedef struct packed {
        logic        store_valid;
        logic [31:0] store_address;
        logic [31:0] store_word;
        logic        register_written;
        logic [31:0] written_value;
        logic        overflow;
    } exec_result_t;

    logic [31:0]  gpr [RegCount];
    logic [31:0]  hi_q, lo_q;
    exec_result_t expected_results [$];

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    task automatic execute_instruction(output exec_result_t r);
        logic [31:0] a, b, imm, addr, mem, value, sw, q, rm, ma, mb;
        logic [4:0]  shift, hshift, dst;
        logic        wr, ovf, stv;
        logic [63:0] prod;
        a = gpr[s_source_index];
        b = gpr[s_target_index];
        imm = sx16(s_immediate);
        addr = s_access_address;
        mem = s_memory_word;
        shift = {addr[1:0], 3'b000};
        hshift = {addr[1], 4'b0000};
        wr = 0; ovf = 0; stv = 0; value = 0; sw = 0; dst = 0;
        case (opcode_t'(s_opcode))
            OP_ADD, OP_ADDU: begin
                value = a + b; dst = s_dest_index; wr = 1;
                if (s_opcode == OP_ADD) ovf = (a[31] ^ value[31]) & (b[31] ^ value[31]);
            end
            OP_ADDI, OP_ADDIU: begin
                value = a + imm; dst = s_target_index; wr = 1;
                if (s_opcode == OP_ADDI) ovf = (a[31] ^ value[31]) & (imm[31] ^ value[31]);
            end
            OP_SUB, OP_SUBU: begin
                value = a - b; dst = s_dest_index; wr = 1;
                if (s_opcode == OP_SUB) ovf = (a[31] ^ b[31]) & (a[31] ^ value[31]);
            end
            OP_MULT: begin
                prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                {hi_q, lo_q} = prod;
            end
            OP_MULTU: begin
                prod = {32'd0, a} * {32'd0, b};
                {hi_q, lo_q} = prod;
            end
            OP_DIV: begin
                if (b == 0) begin
                    lo_q = a[31] ? 32'd1 : MASK_WORD;
                    hi_q = a;
                end else begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    rm = ma % mb;
                    lo_q = (a[31] ^ b[31]) ? -q : q;
                    hi_q = a[31] ? -rm : rm;
                end
            end
            OP_DIVU: begin
                if (b == 0) begin
                    lo_q = MASK_WORD; hi_q = a;
                end else begin
                    lo_q = a / b; hi_q = a % b;
                end
            end
            OP_LB:  begin value = {{24{mem[shift+7]}}, 8'(mem >> shift)};
                dst = s_target_index; wr = 1; end
            OP_LBU: begin value = (mem >> shift) & 32'hff; dst = s_target_index; wr = 1; end
            OP_LH:  begin value = sx16(16'(mem >> hshift)); dst = s_target_index; wr = 1; end
            OP_LHU: begin value = (mem >> hshift) & 32'hffff; dst = s_target_index; wr = 1; end
            OP_LW:  begin value = mem; dst = s_target_index; wr = 1; end
            OP_LWL: begin
                value = (b & (MASK_LOW24 >> shift)) | (mem << (6'd24 - shift));
                dst = s_target_index; wr = 1;
            end
            OP_LWR: begin
                value = (b & (MASK_HIGH24 << (6'd24 - shift))) | (mem >> shift);
                dst = s_target_index; wr = 1;
            end
            OP_SB: begin
                sw = (mem & ~(32'hff << shift)) | ((b & 32'hff) << shift); stv = 1;
            end
            OP_SH: begin
                sw = (mem & ~(32'hffff << hshift)) | ((b & 32'hffff) << hshift); stv = 1;
            end
            OP_SW:  begin sw = b; stv = 1; end
            OP_SWL: begin
                sw = (b >> (6'd24 - shift)) | (mem & (MASK_HIGH24 << shift)); stv = 1;
            end
            OP_SWR: begin
                sw = (b << shift) | (mem & (MASK_LOW24 >> (6'd24 - shift))); stv = 1;
            end
            default: ;
        endcase
        if (ovf || dst == 0) wr = 0;
        if (wr) gpr[dst] = value;
        else value = 0;
        gpr[0] = 0;
        r.store_valid = stv;
        r.store_address = stv ? (addr & MASK_ALIGN) : 32'd0;
        r.store_word = stv ? sw : 32'd0;
        r.register_written = wr;
        r.written_value = value;
        r.overflow = ovf;
    endtask

    always @(posedge aclk) begin
        exec_result_t exp_r, got_r;
        if (!aresetn) begin
            for (int i = 0; i < RegCount; i++) gpr[i] = 0;
            hi_q = 0; lo_q = 0;
            error_count = 0;
            result_count = 0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                execute_instruction(exp_r);
                expected_results.push_back(exp_r);
            end
            if (m_valid && m_ready) begin
                got_r = '{m_store_valid, m_store_address, m_store_word,
                          m_register_written, m_written_value, m_overflow};
                result_count++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result %h", $time, got_r);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.store_valid !== got_r.store_valid)
                        $display("%0t: store_valid exp %h got %h", $time,
                                 exp_r.store_valid, got_r.store_valid);
                    if (exp_r.store_address !== got_r.store_address)
                        $display("%0t: store_address exp %h got %h", $time,
                                 exp_r.store_address, got_r.store_address);
                    if (exp_r.store_word !== got_r.store_word)
                        $display("%0t: store_word exp %h got %h", $time,
                                 exp_r.store_word, got_r.store_word);
                    if (exp_r.register_written !== got_r.register_written)
                        $display("%0t: register_written exp %h got %h", $time,
                                 exp_r.register_written, got_r.register_written);
                    if (exp_r.written_value !== got_r.written_value)
                        $display("%0t: written_value exp %h got %h", $time,
                                 exp_r.written_value, got_r.written_value);
                    if (exp_r.overflow !== got_r.overflow)
                        $display("%0t: overflow exp %h got %h", $time,
                                 exp_r.overflow, got_r.overflow);
                    if (exp_r !== got_r) error_count++;
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// File: bench/mips_integer_execute_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_test
// Drives directed and random instruction streams into the execute unit under
// varied idle and stall patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_test;
    import miu_pkg::*;

    localparam int CycleLimit = 400000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [4:0]  s_opcode = 0;
    logic [4:0]  s_dest_index = 0;
    logic [4:0]  s_source_index = 0;
    logic [4:0]  s_target_index = 0;
    logic [15:0] s_immediate = 0;
    logic [31:0] s_access_address = 0;
    logic [31:0] s_memory_word = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_store_valid;
    logic [31:0] m_store_address;
    logic [31:0] m_store_word;
    logic        m_register_written;
    logic [31:0] m_written_value;
    logic        m_overflow;
    int          error_count, pending_count, result_count;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_off = 0;
    int          cycle_count = 0;
    int          sent_count = 0;

    mips_integer_execute_unit dut (.*);
    mips_integer_execute_unit_checker checker_i (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_off) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_instruction(logic [4:0] op, logic [4:0] rd, logic [4:0] rs,
                                    logic [4:0] rt, logic [15:0] imm,
                                    logic [31:0] addr, logic [31:0] mem);
        // drop valid only when idling, so back-to-back items keep it high
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1;
        s_opcode <= op; s_dest_index <= rd; s_source_index <= rs;
        s_target_index <= rt; s_immediate <= imm;
        s_access_address <= addr; s_memory_word <= mem;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // Small register indexes often so operands carry earlier results.
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return MASK_WORD;
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic [4:0] op;
        op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 22))
                                       : 5'($urandom_range(OP_SWR));
        send_instruction(op, pick_reg(), pick_reg(), pick_reg(), 16'($urandom),
                         $urandom, $urandom);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        // Seed registers with extreme values via loads.
        send_instruction(OP_LW, 0, 0, 1, 0, 0, 32'h7fffffff);
        send_instruction(OP_LW, 0, 0, 2, 0, 0, 32'h80000000);
        send_instruction(OP_LW, 0, 0, 3, 0, 0, MASK_WORD);
        send_instruction(OP_LW, 0, 0, 4, 0, 0, 32'h12345678);
        send_instruction(OP_LW, 0, 0, 0, 0, 0, 32'hdeadbeef);    // dropped write
        send_instruction(OP_ADD, 5, 1, 1, 0, 0, 0);              // overflow
        send_instruction(OP_ADD, 0, 2, 2, 0, 0, 0);              // overflow to r0
        send_instruction(OP_ADDI, 0, 1, 6, 16'h7fff, 0, 0);      // overflow
        send_instruction(OP_ADDIU, 0, 2, 7, 16'h8000, 0, 0);
        send_instruction(OP_SUB, 8, 2, 1, 0, 0, 0);              // overflow
        send_instruction(OP_ADDU, 9, 3, 1, 0, 0, 0);
        send_instruction(OP_SUBU, 10, 0, 3, 0, 0, 0);
        send_instruction(OP_MULT, 0, 2, 3, 0, 0, 0);
        send_instruction(OP_MULTU, 0, 3, 3, 0, 0, 0);
        send_instruction(OP_DIV, 0, 4, 0, 0, 0, 0);              // signed by zero
        send_instruction(OP_DIV, 0, 2, 0, 0, 0, 0);
        send_instruction(OP_DIVU, 0, 3, 0, 0, 0, 0);
        send_instruction(OP_DIV, 0, 2, 3, 0, 0, 0);              // most negative / -1
        send_instruction(OP_LB, 0, 0, 11, 0, 32'h3, 32'h80ff7f01);
        send_instruction(OP_LHU, 0, 0, 12, 0, 32'h3, 32'h80ff7f01); // odd address
        send_instruction(OP_LH, 0, 0, 13, 0, 32'h1, 32'h80ff8001);
        send_instruction(OP_LWL, 0, 0, 4, 0, 32'h1, 32'haabbccdd);
        send_instruction(OP_LWR, 0, 0, 4, 0, 32'h2, 32'haabbccdd);
        send_instruction(OP_SWL, 0, 0, 4, 0, 32'hffffffff, 32'h11223344);
        send_instruction(OP_SWR, 0, 0, 4, 0, 32'h00000002, 32'h11223344);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 60 : 17) : 0;
            recv_stall_pct = (ph == 2) ? 60 : ((ph == 3) ? 17 : 0);
            for (int i = 0; i < 160; i++) send_random();
        end
        fork
            begin
                hold_off = 1;
                repeat (200) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 20; i++) send_random();
        join
        s_valid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("%0d instructions sent, %0d results checked over four idle patterns",
                 sent_count, result_count);
        $display("and a long receiver hold-off; %0d errors", error_count);
        if (error_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
